>>> rtl/quaternion_vector_rotate_top_assert.svh
// Assertion macros shared by the quaternion rotation checker.
`ifndef QUATERNION_VECTOR_ROTATE_TOP_ASSERT_SVH
`define QUATERNION_VECTOR_ROTATE_TOP_ASSERT_SVH

// Concurrent assertion that is switched off while reset is high.
`define QVR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is also checked while reset is high.
`define QVR_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/qvr_pkg.sv
// Package with widths, constants and beat types of the quaternion rotation block.
package qvr_pkg;

   // Field and fixed-point formats.
   localparam int FIELD_W        = 16;
   localparam int QUAT_FRAC_BITS = 14;
   localparam int VEC_WIDTH      = 16;
   localparam int SHIFT_BITS     = 2 * QUAT_FRAC_BITS;

   // Internal widths: q*v product, T part, T*q product, R sum.
   localparam int PROD1_W = 2 * FIELD_W;
   localparam int T_W     = PROD1_W + 1;
   localparam int PROD2_W = T_W + FIELD_W;
   localparam int R_W     = PROD2_W + 2;
   localparam int SH_W    = R_W - SHIFT_BITS;

   // Pipeline depth: two product stages, two sum stages, output register.
   localparam int NUM_STAGES = 5;

   // Rounding bias and saturation limits.
   localparam logic signed [R_W-1:0]  ROUND_HALF = R_W'(64'sd1 <<< (SHIFT_BITS - 1));
   localparam logic signed [SH_W-1:0] SAT_MAX    =
      SH_W'((64'sd1 <<< (VEC_WIDTH - 1)) - 64'sd1);
   localparam logic signed [SH_W-1:0] SAT_MIN    = SH_W'(-(64'sd1 <<< (VEC_WIDTH - 1)));

   // Payload of one request beat.
   typedef struct packed {
      logic signed [FIELD_W-1:0] rot_w;
      logic signed [FIELD_W-1:0] rot_x;
      logic signed [FIELD_W-1:0] rot_y;
      logic signed [FIELD_W-1:0] rot_z;
      logic signed [FIELD_W-1:0] vec_x;
      logic signed [FIELD_W-1:0] vec_y;
      logic signed [FIELD_W-1:0] vec_z;
   } qvr_req_type;

   // Payload of one response beat.
   typedef struct packed {
      logic signed [FIELD_W-1:0] out_x;
      logic signed [FIELD_W-1:0] out_y;
      logic signed [FIELD_W-1:0] out_z;
   } qvr_rsp_type;

   // Per-stage load enables from the pipeline control to the datapath.
   typedef struct packed {
      logic [NUM_STAGES-1:0] load;
   } qvr_ctrl_type;

endpackage

>>> rtl/qvr_if.sv
// Valid/ready channel interfaces for request and response beats.
interface qvr_req_if;
   import qvr_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [FIELD_W-1:0] rot_w;
   logic signed [FIELD_W-1:0] rot_x;
   logic signed [FIELD_W-1:0] rot_y;
   logic signed [FIELD_W-1:0] rot_z;
   logic signed [FIELD_W-1:0] vec_x;
   logic signed [FIELD_W-1:0] vec_y;
   logic signed [FIELD_W-1:0] vec_z;

   modport source (output valid, rot_w, rot_x, rot_y, rot_z, vec_x, vec_y, vec_z,
                   input ready);
   modport sink   (input valid, rot_w, rot_x, rot_y, rot_z, vec_x, vec_y, vec_z,
                   output ready);
endinterface

interface qvr_rsp_if;
   import qvr_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [FIELD_W-1:0] out_x;
   logic signed [FIELD_W-1:0] out_y;
   logic signed [FIELD_W-1:0] out_z;

   modport source (output valid, out_x, out_y, out_z, input ready);
   modport sink   (input valid, out_x, out_y, out_z, output ready);
endinterface

>>> rtl/qvr_datapath.sv
// Five-stage datapath computing q * (0, v) * conj(q) with rounding and saturation.
module qvr_datapath (
   input  logic                 clock,
   input  qvr_pkg::qvr_ctrl_type ctrl,
   input  qvr_pkg::qvr_req_type  req_data,
   output qvr_pkg::qvr_rsp_type  rsp_data
);
   import qvr_pkg::*;

   // Stage 0: products of quaternion and vector parts.
   logic signed [PROD1_W-1:0] p_ff [12];
   logic signed [PROD1_W-1:0] p_in [12];
   logic signed [FIELD_W-1:0] q0_ff [4];

   // Stage 1: T = q * (0, v), order w, x, y, z.
   logic signed [T_W-1:0]     t_ff [4];
   logic signed [T_W-1:0]     t_in [4];
   logic signed [FIELD_W-1:0] q1_ff [4];

   // Stage 2: products of T and quaternion parts.
   logic signed [PROD2_W-1:0] m_ff [12];
   logic signed [PROD2_W-1:0] m_in [12];

   // Stage 3: biased vector part of R.
   logic signed [R_W-1:0]     r_ff [3];
   logic signed [R_W-1:0]     r_in [3];

   // Stage 4: rounded and saturated output.
   logic signed [FIELD_W-1:0] o_ff [3];
   logic signed [FIELD_W-1:0] o_in [3];
   logic signed [SH_W-1:0]    sh   [3];

   // Quaternion-times-vector products.
   always_comb begin
      p_in[0]  = PROD1_W'(req_data.rot_x) * PROD1_W'(req_data.vec_x);
      p_in[1]  = PROD1_W'(req_data.rot_y) * PROD1_W'(req_data.vec_y);
      p_in[2]  = PROD1_W'(req_data.rot_z) * PROD1_W'(req_data.vec_z);
      p_in[3]  = PROD1_W'(req_data.rot_w) * PROD1_W'(req_data.vec_x);
      p_in[4]  = PROD1_W'(req_data.rot_y) * PROD1_W'(req_data.vec_z);
      p_in[5]  = PROD1_W'(req_data.rot_z) * PROD1_W'(req_data.vec_y);
      p_in[6]  = PROD1_W'(req_data.rot_w) * PROD1_W'(req_data.vec_y);
      p_in[7]  = PROD1_W'(req_data.rot_z) * PROD1_W'(req_data.vec_x);
      p_in[8]  = PROD1_W'(req_data.rot_x) * PROD1_W'(req_data.vec_z);
      p_in[9]  = PROD1_W'(req_data.rot_w) * PROD1_W'(req_data.vec_z);
      p_in[10] = PROD1_W'(req_data.rot_x) * PROD1_W'(req_data.vec_y);
      p_in[11] = PROD1_W'(req_data.rot_y) * PROD1_W'(req_data.vec_x);
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[0]) begin
         p_ff     <= p_in;
         q0_ff[0] <= req_data.rot_w;
         q0_ff[1] <= req_data.rot_x;
         q0_ff[2] <= req_data.rot_y;
         q0_ff[3] <= req_data.rot_z;
      end
   end

   // Sums that form T; three products cannot overflow T_W bits.
   always_comb begin
      t_in[0] = -(T_W'(p_ff[0]) + T_W'(p_ff[1]) + T_W'(p_ff[2]));
      t_in[1] = T_W'(p_ff[3]) + T_W'(p_ff[4]) - T_W'(p_ff[5]);
      t_in[2] = T_W'(p_ff[6]) + T_W'(p_ff[7]) - T_W'(p_ff[8]);
      t_in[3] = T_W'(p_ff[9]) + T_W'(p_ff[10]) - T_W'(p_ff[11]);
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[1]) begin
         t_ff  <= t_in;
         q1_ff <= q0_ff;
      end
   end

   // Products of T with the quaternion parts (w, x, y, z at q1_ff[0..3]).
   always_comb begin
      m_in[0]  = PROD2_W'(t_ff[0]) * PROD2_W'(q1_ff[1]);
      m_in[1]  = PROD2_W'(t_ff[1]) * PROD2_W'(q1_ff[0]);
      m_in[2]  = PROD2_W'(t_ff[2]) * PROD2_W'(q1_ff[3]);
      m_in[3]  = PROD2_W'(t_ff[3]) * PROD2_W'(q1_ff[2]);
      m_in[4]  = PROD2_W'(t_ff[0]) * PROD2_W'(q1_ff[2]);
      m_in[5]  = PROD2_W'(t_ff[1]) * PROD2_W'(q1_ff[3]);
      m_in[6]  = PROD2_W'(t_ff[2]) * PROD2_W'(q1_ff[0]);
      m_in[7]  = PROD2_W'(t_ff[3]) * PROD2_W'(q1_ff[1]);
      m_in[8]  = PROD2_W'(t_ff[0]) * PROD2_W'(q1_ff[3]);
      m_in[9]  = PROD2_W'(t_ff[1]) * PROD2_W'(q1_ff[2]);
      m_in[10] = PROD2_W'(t_ff[2]) * PROD2_W'(q1_ff[1]);
      m_in[11] = PROD2_W'(t_ff[3]) * PROD2_W'(q1_ff[0]);
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[2]) begin
         m_ff <= m_in;
      end
   end

   // Vector part of T * conj(q), with the rounding half added.
   always_comb begin
      r_in[0] = -R_W'(m_ff[0]) + R_W'(m_ff[1]) - R_W'(m_ff[2]) + R_W'(m_ff[3])
                + ROUND_HALF;
      r_in[1] = -R_W'(m_ff[4]) + R_W'(m_ff[5]) + R_W'(m_ff[6]) - R_W'(m_ff[7])
                + ROUND_HALF;
      r_in[2] = -R_W'(m_ff[8]) - R_W'(m_ff[9]) + R_W'(m_ff[10]) + R_W'(m_ff[11])
                + ROUND_HALF;
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[3]) begin
         r_ff <= r_in;
      end
   end

   // Drop the fraction bits (floor) and clamp to the signed vector range.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sh[i] = r_ff[i][R_W-1:SHIFT_BITS];
         if (sh[i] > SAT_MAX) begin
            o_in[i] = SAT_MAX[FIELD_W-1:0];
         end else if (sh[i] < SAT_MIN) begin
            o_in[i] = SAT_MIN[FIELD_W-1:0];
         end else begin
            o_in[i] = sh[i][FIELD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[4]) begin
         o_ff <= o_in;
      end
   end

   assign rsp_data.out_x = o_ff[0];
   assign rsp_data.out_y = o_ff[1];
   assign rsp_data.out_z = o_ff[2];

endmodule

>>> rtl/quaternion_vector_rotate_top.sv
// Top level of the quaternion vector rotation block: pipeline control and channels.
//
//   Channel    Direction  Handshake      Payload
//   req_chan   in         valid/ready    rot_w rot_x rot_y rot_z vec_x vec_y vec_z
//   rsp_chan   out        valid/ready    out_x out_y out_z
//
// One beat enters per cycle unless a stalled response has filled every stage; its
// result passes the product, T sum, product, R sum and output registers in turn.
// The depth is set by two multiplier stages, two adder stages and the output register.
// Reset clears only the stage valid bits; the datapath registers are not reset.
// A stalled response holds its beat; empty stages ahead of it still fill, so requests
// are taken until every stage holds a beat.
module quaternion_vector_rotate_top (
   input logic      clock,
   input logic      reset,
   qvr_req_if.sink   req_chan,
   qvr_rsp_if.source rsp_chan
);
   import qvr_pkg::*;

   logic [NUM_STAGES-1:0] vld_ff;
   logic [NUM_STAGES-1:0] vld_in;
   logic [NUM_STAGES-1:0] adv;
   qvr_ctrl_type          ctrl;
   qvr_req_type           req_data;
   qvr_rsp_type           rsp_data;

   // A stage may load when it is empty or its beat moves on.
   always_comb begin
      adv[NUM_STAGES-1] = !vld_ff[NUM_STAGES-1] || rsp_chan.ready;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         adv[i] = !vld_ff[i] || adv[i+1];
      end
   end

   // Valid bits travel with the data.
   always_comb begin
      vld_in[0] = adv[0] ? req_chan.valid : vld_ff[0];
      for (int i = 1; i < NUM_STAGES; i++) begin
         vld_in[i] = adv[i] ? vld_ff[i-1] : vld_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign ctrl.load      = adv;
   assign req_chan.ready = adv[0];

   // Request beat payload.
   assign req_data.rot_w = req_chan.rot_w;
   assign req_data.rot_x = req_chan.rot_x;
   assign req_data.rot_y = req_chan.rot_y;
   assign req_data.rot_z = req_chan.rot_z;
   assign req_data.vec_x = req_chan.vec_x;
   assign req_data.vec_y = req_chan.vec_y;
   assign req_data.vec_z = req_chan.vec_z;

   qvr_datapath u_datapath (
      .clock    (clock),
      .ctrl     (ctrl),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

   // Response beat.
   assign rsp_chan.valid = vld_ff[NUM_STAGES-1];
   assign rsp_chan.out_x = rsp_data.out_x;
   assign rsp_chan.out_y = rsp_data.out_y;
   assign rsp_chan.out_z = rsp_data.out_z;

endmodule

>>> rtl/qvr_checker.sv
// Port-level checker for the quaternion rotation block and its bind statement.
`include "quaternion_vector_rotate_top_assert.svh"

module qvr_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [qvr_pkg::FIELD_W-1:0] rsp_out_x,
   input logic signed [qvr_pkg::FIELD_W-1:0] rsp_out_y,
   input logic signed [qvr_pkg::FIELD_W-1:0] rsp_out_z
);
   import qvr_pkg::*;

   localparam int CNT_W = $clog2(NUM_STAGES + 1);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             req_beat;
   logic             rsp_beat;

   // Beats in flight inside the block.
   assign req_beat = req_valid && req_ready;
   assign rsp_beat = rsp_valid && rsp_ready;

   always_comb begin
      count_in = count_ff + CNT_W'(req_beat) - CNT_W'(rsp_beat);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // A stalled response keeps its beat.
   `QVR_ASSERT(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_x)
         && $stable(rsp_out_y) && $stable(rsp_out_z),
      "response beat changed while stalled")

   // The pipeline never holds more beats than it has stages.
   `QVR_ASSERT(a_occupancy, clock, reset,
      count_ff <= CNT_W'(NUM_STAGES),
      "more beats in flight than pipeline stages")

   // No response without a request beat behind it.
   `QVR_ASSERT(a_no_phantom, clock, reset,
      rsp_valid |-> count_ff != '0,
      "response beat without a pending request")

   // An empty block takes a request at once.
   `QVR_ASSERT(a_empty_ready, clock, reset,
      count_ff == '0 |-> req_ready,
      "empty block not ready for a request")

   // Reset empties the pipeline.
   `QVR_ASSERT_ALWAYS(a_reset_empty, clock,
      reset |=> !rsp_valid,
      "response valid right after reset")

endmodule

bind quaternion_vector_rotate_top qvr_checker u_qvr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_out_x (rsp_chan.out_x),
   .rsp_out_y (rsp_chan.out_y),
   .rsp_out_z (rsp_chan.out_z)
);
